// File: rtl/core/rdbs_pkg.sv
package rdbs_pkg;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_ACCESS = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // ok chunks plus the closing error result
  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned NCHUNK_W    = 4;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_ACCESS
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] base;
    logic [31:0] limit;
    logic [31:0] start;
    logic [15:0] len;
    logic        zero_len;
    logic        wr;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  region_index;
    logic [31:0] chunk_address;
    logic [15:0] chunk_length;
    logic        chunk_is_write;
    logic        last;
  } res_t;

endpackage

// File: rtl/core/rdbs_front.sv
module rdbs_front import rdbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [31:0] region_base_in_i,
  input  logic [31:0] region_limit_in_i,
  input  logic [31:0] start_address_i,
  input  logic [15:0] byte_length_i,
  input  logic        write_access_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_take_i
);

  cmd_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, keep;
  cmd_t       cmd_in;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];
  assign accept      = push && !full;
  // reserved mode code is swallowed here and never reaches the back end
  assign keep        = accept && (mode_i != MODE_RSVD);

  always_comb begin
    cmd_in.base     = region_base_in_i;
    cmd_in.limit    = region_limit_in_i;
    cmd_in.start    = start_address_i;
    cmd_in.len      = byte_length_i;
    cmd_in.zero_len = (byte_length_i == 16'd0);
    cmd_in.wr       = write_access_i;
    case (mode_i)
      MODE_CLEAR:  cmd_in.op = OP_CLEAR;
      MODE_APPEND: cmd_in.op = OP_APPEND;
      default:     cmd_in.op = OP_ACCESS;
    endcase
  end

  assign cnt_d = cnt_q + 2'(keep) - 2'(cmd_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (keep) wp_q <= ~wp_q;
      if (cmd_take_i) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) fifo_q[wp_q] <= cmd_in;
  end

endmodule

// File: rtl/core/rdbs_back.sv
module rdbs_back import rdbs_pkg::*; #(
  parameter int unsigned REGIONS   = 8,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_take_o,
  input  logic res_space_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam int unsigned IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int unsigned CNT_W = $clog2(REGIONS + 1);
  localparam int unsigned RW    = (ADDR_BITS + 1 > 17) ? ADDR_BITS + 1 : 17;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EMIT
  } state_e;

  state_e               state_q;
  logic [ADDR_BITS-1:0] base_q [REGIONS];
  logic [ADDR_BITS-1:0] lim_q  [REGIONS];
  logic [CNT_W-1:0]     count_q;
  logic [ADDR_BITS-1:0] cur_q;
  logic [15:0]          rest_q;
  logic                 wr_q;
  logic [NCHUNK_W-1:0]  nchunk_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     idx_q;

  logic                 tbl_full, tbl_we;
  logic [REGIONS-1:0]   hit;
  logic                 hit_any;
  logic [IDX_W-1:0]     hit_idx;
  logic [RW-1:0]        room, rest_w, next_w;
  logic                 fits;
  logic [15:0]          chunk_len;

  assign tbl_full = (count_q == CNT_W'(REGIONS));
  assign tbl_we   = (state_q == S_IDLE) && cmd_valid_i && res_space_i &&
                    (cmd_i.op == OP_APPEND) && !tbl_full;
  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i && res_space_i;

  // parallel compare against every live region, lowest index wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < REGIONS; i++) begin
      hit[i] = (CNT_W'(i) < count_q) && (cur_q >= base_q[i]) && (cur_q <= lim_q[i]);
    end
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign room      = RW'(lim_q[idx_q]) - RW'(cur_q) + RW'(1);
  assign rest_w    = RW'(rest_q);
  assign fits      = (rest_w <= room);
  assign chunk_len = fits ? rest_q : room[15:0];
  assign next_w    = RW'(cur_q) + RW'(chunk_len);

  always_comb begin
    res_push_o           = 1'b0;
    res_o.status         = STAT_OK;
    res_o.region_index   = 3'd0;
    res_o.chunk_address  = 32'd0;
    res_o.chunk_length   = 16'd0;
    res_o.chunk_is_write = 1'b0;
    res_o.last           = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (cmd_take_o) begin
          case (cmd_i.op)
            OP_CLEAR: res_push_o = 1'b1;
            OP_APPEND: begin
              res_push_o = 1'b1;
              if (tbl_full) res_o.status = STAT_FULL;
              else res_o.region_index = 3'(count_q);
            end
            default: begin
              if (cmd_i.zero_len) begin
                res_push_o           = 1'b1;
                res_o.chunk_address  = 32'(cmd_i.start[ADDR_BITS-1:0]);
                res_o.chunk_is_write = cmd_i.wr;
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        res_push_o           = res_space_i;
        res_o.chunk_address  = 32'(cur_q);
        res_o.chunk_is_write = wr_q;
        if (hit_q) begin
          res_o.region_index = 3'(idx_q);
          res_o.chunk_length = chunk_len;
          res_o.last         = fits;
        end else begin
          res_o.status = STAT_MISS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cur_q    <= '0;
      rest_q   <= '0;
      wr_q     <= 1'b0;
      nchunk_q <= '0;
      hit_q    <= 1'b0;
      idx_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_take_o) begin
            case (cmd_i.op)
              OP_CLEAR:  count_q <= '0;
              OP_APPEND: if (!tbl_full) count_q <= count_q + CNT_W'(1);
              default: begin
                if (!cmd_i.zero_len) begin
                  cur_q    <= cmd_i.start[ADDR_BITS-1:0];
                  rest_q   <= cmd_i.len;
                  wr_q     <= cmd_i.wr;
                  nchunk_q <= '0;
                  state_q  <= S_LOOK;
                end
              end
            endcase
          end
        end
        S_LOOK: begin
          // out of result slots reads as a miss at the current address
          hit_q   <= hit_any && (nchunk_q != NCHUNK_W'(MAX_RESULTS - 1));
          idx_q   <= hit_idx;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (res_space_i) begin
            if (!hit_q || fits) begin
              state_q <= S_IDLE;
            end else begin
              cur_q    <= next_w[ADDR_BITS-1:0];
              rest_q   <= rest_q - chunk_len;
              nchunk_q <= nchunk_q + NCHUNK_W'(1);
              state_q  <= S_LOOK;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      base_q[count_q[IDX_W-1:0]] <= cmd_i.base[ADDR_BITS-1:0];
      lim_q[count_q[IDX_W-1:0]]  <= cmd_i.limit[ADDR_BITS-1:0];
    end
  end

endmodule

// File: rtl/core/rdbs_out_q.sv
module rdbs_out_q import rdbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_push_i,
  input  res_t res_i,
  output logic res_space_o,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  res_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       take;

  assign res_space_o = (cnt_q != 2'd2);
  assign empty       = (cnt_q == 2'd0);
  assign take        = pop && !empty;
  assign res_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(res_push_i) - 2'(take);
      if (res_push_i) wp_q <= ~wp_q;
      if (take) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) fifo_q[wp_q] <= res_i;
  end

endmodule

// File: rtl/core/region_decode_burst_splitter.sv
// Flow: a clear, append or zero length access result is registered in the command queue, then
//   in the result queue; an access chunk also passes the compare and sizing states first.
// Throughput: clear and append run one per cycle while the result queue has space; an
//   access runs compare then sizing per result in the back end, taking no new command.
// Reset: asynchronous, active low; empties both queues and the region table (count only).
module region_decode_burst_splitter import rdbs_pkg::*; #(
  parameter int unsigned REGIONS   = 8,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [31:0] region_base_in_i,
  input  logic [31:0] region_limit_in_i,
  input  logic [31:0] start_address_i,
  input  logic [15:0] byte_length_i,
  input  logic        write_access_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [2:0]  region_index_o,
  output logic [31:0] chunk_address_o,
  output logic [15:0] chunk_length_o,
  output logic        chunk_is_write_o,
  output logic        last_o
);

  logic cmd_valid, cmd_take, res_push, res_space;
  cmd_t cmd;
  res_t res_in, res_out;

  rdbs_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .mode_i,
    .region_base_in_i,
    .region_limit_in_i,
    .start_address_i,
    .byte_length_i,
    .write_access_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  rdbs_back #(
    .REGIONS   (REGIONS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_space_i (res_space),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  rdbs_out_q u_out_q (
    .clk_i,
    .rst_ni,
    .res_push_i  (res_push),
    .res_i       (res_in),
    .res_space_o (res_space),
    .empty,
    .pop,
    .res_o       (res_out)
  );

  assign status_o         = res_out.status;
  assign region_index_o   = res_out.region_index;
  assign chunk_address_o  = res_out.chunk_address;
  assign chunk_length_o   = res_out.chunk_length;
  assign chunk_is_write_o = res_out.chunk_is_write;
  assign last_o           = res_out.last;

endmodule

// File: rtl/core/rdbs_checker.sv
module rdbs_checker import rdbs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status_o,
  input logic [2:0]  region_index_o,
  input logic [31:0] chunk_address_o,
  input logic [15:0] chunk_length_o,
  input logic        last_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty in reset");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != STAT_OK) |-> (last_o && chunk_length_o == 16'd0))
    else $error("error result not final or carries bytes");

  a_mid_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> (status_o == STAT_OK && chunk_length_o != 16'd0))
    else $error("non-final result is not a nonempty ok chunk");

  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STAT_FULL) |-> (region_index_o == 3'd0 && chunk_address_o == 32'd0))
    else $error("table full result with nonzero fields");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(chunk_address_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind region_decode_burst_splitter rdbs_checker u_rdbs_checker (.*);
